@@ rtl/rar_pkg.sv @@
// ----------------------------------------------------------------------------
// rar_pkg: shared types and constants for the rational arithmetic unit
// Operand width, operation codes and the control/status bundles between
// the sequencer and the datapath.
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int WIDTH = 16;
    // shift count for the common power of two in the binary gcd
    localparam int KW    = $clog2(WIDTH);
    // divider step counter, holds WIDTH itself
    localparam int CW    = $clog2(WIDTH + 1);

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_RED = 2'd3
    } cmd_e_t;

    // sequencer -> datapath
    typedef struct packed {
        logic load;          // capture request fields
        logic mul_p;         // first product
        logic mul_q;         // cross product a_den * b_num
        logic mul_d;         // denominator product
        logic gcd_init;      // sign fix and gcd operand load
        logic gcd_step;      // one binary gcd step
        logic div_load_num;  // form g, start numerator division
        logic div_load_den;  // keep numerator quotient, start denominator
        logic div_step;      // one restoring division step
        logic res_load;      // write the output register
    } ctrl_cmd_t;

    // datapath -> sequencer
    typedef struct packed {
        logic is_reduce;
        logic is_mul;
        logic den_eq;
        logic an_zero;
        logic gcd_done;
        logic div_last;
    } dp_stat_t;

    // two's complement magnitude; the most negative value maps to 2^(WIDTH-1)
    function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] v);
        logic [WIDTH-1:0] r;
        r = v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
        return r;
    endfunction

endpackage

@@ rtl/rar_dp.sv @@
// ----------------------------------------------------------------------------
// rar_dp: datapath of the rational arithmetic unit
// Operand registers, one shared multiplier, binary gcd unit, restoring
// divider and the output register.
// ----------------------------------------------------------------------------
module rar_dp (
    input  logic                              clk,
    input  rar_pkg::ctrl_cmd_t                ctl,
    output rar_pkg::dp_stat_t                 stat,
    input  logic [1:0]                        command,
    input  logic signed [rar_pkg::WIDTH-1:0]  a_num,
    input  logic signed [rar_pkg::WIDTH-1:0]  a_den,
    input  logic signed [rar_pkg::WIDTH-1:0]  b_num,
    input  logic signed [rar_pkg::WIDTH-1:0]  b_den,
    output logic signed [rar_pkg::WIDTH-1:0]  res_num,
    output logic signed [rar_pkg::WIDTH-1:0]  res_den
);

    localparam int W = rar_pkg::WIDTH;

    rar_pkg::cmd_e_t        cmd_reg;
    logic [W-1:0]           an_reg, ad_reg, bn_reg, bd_reg;
    logic [W-1:0]           p_reg, q_reg, d_reg;
    logic [W-1:0]           sn_reg, sd_reg;
    logic [W-1:0]           x_reg, y_reg, x_next, y_next;
    logic [rar_pkg::KW-1:0] k_reg, k_next;
    logic [W-1:0]           g_reg;
    logic [W-1:0]           rem_reg, rem_next;
    logic [W-1:0]           quo_reg, quo_next;
    logic [W-1:0]           qn_reg;
    logic [rar_pkg::CW-1:0] cnt_reg;
    logic [W-1:0]           rn_reg, rd_reg, rn_next, rd_next;

    logic [W-1:0]           mul_a, mul_b, prod;
    logic [W-1:0]           sn_fix, sd_fix;
    logic [W:0]             r2, r2_diff;

    // operand selection for the shared multiplier, low WIDTH bits kept
    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        if (ctl.mul_q)
        begin
            mul_a = ad_reg;
            mul_b = bn_reg;
        end
        else if (ctl.mul_d)
        begin
            mul_a = ad_reg;
            mul_b = bd_reg;
        end
        else if (cmd_reg == rar_pkg::CMD_MUL)
        begin
            mul_b = bn_reg;
        end
    end

    assign prod = mul_a * mul_b;

    // negative denominator: move sign to numerator (wrapping)
    assign sn_fix = ad_reg[W-1] ? (~an_reg + W'(1)) : an_reg;
    assign sd_fix = ad_reg[W-1] ? (~ad_reg + W'(1)) : ad_reg;

    // binary gcd step, operands held as magnitudes
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        k_next = k_reg;
        priority if (!x_reg[0] && !y_reg[0])
        begin
            x_next = x_reg >> 1;
            y_next = y_reg >> 1;
            k_next = k_reg + rar_pkg::KW'(1);
        end
        else if (!x_reg[0])
        begin
            x_next = x_reg >> 1;
        end
        else if (!y_reg[0])
        begin
            y_next = y_reg >> 1;
        end
        else if (x_reg >= y_reg)
        begin
            x_next = (x_reg - y_reg) >> 1;
        end
        else
        begin
            y_next = (y_reg - x_reg) >> 1;
        end
    end

    // restoring division step
    assign r2      = {rem_reg, quo_reg[W-1]};
    assign r2_diff = r2 - {1'b0, g_reg};

    always_comb
    begin
        if (!r2_diff[W])
        begin
            rem_next = r2_diff[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b1};
        end
        else
        begin
            rem_next = r2[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b0};
        end
    end

    // result selection
    always_comb
    begin
        rn_next = an_reg + bn_reg;
        rd_next = ad_reg;
        unique case (cmd_reg)
            rar_pkg::CMD_ADD:
            begin
                if (ad_reg != bd_reg)
                begin
                    rn_next = p_reg + q_reg;
                    rd_next = d_reg;
                end
            end
            rar_pkg::CMD_SUB:
            begin
                rn_next = an_reg - bn_reg;
                if (ad_reg != bd_reg)
                begin
                    rn_next = p_reg - q_reg;
                    rd_next = d_reg;
                end
            end
            rar_pkg::CMD_MUL:
            begin
                rn_next = p_reg;
                rd_next = d_reg;
            end
            rar_pkg::CMD_RED:
            begin
                if (an_reg == '0)
                begin
                    rn_next = '0;
                    rd_next = W'(1);
                end
                else
                begin
                    rn_next = sn_reg[W-1] ? (~qn_reg + W'(1)) : qn_reg;
                    rd_next = sd_reg[W-1] ? (~quo_reg + W'(1)) : quo_reg;
                end
            end
            default:
            begin
                rn_next = an_reg;
                rd_next = ad_reg;
            end
        endcase
    end

    // operand and result registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= rar_pkg::cmd_e_t'(command);
            an_reg  <= a_num;
            ad_reg  <= a_den;
            bn_reg  <= b_num;
            bd_reg  <= b_den;
        end
        if (ctl.mul_p)
        begin
            p_reg <= prod;
        end
        if (ctl.mul_q)
        begin
            q_reg <= prod;
        end
        if (ctl.mul_d)
        begin
            d_reg <= prod;
        end
        if (ctl.res_load)
        begin
            rn_reg <= rn_next;
            rd_reg <= rd_next;
        end
    end

    // gcd and divider registers
    always_ff @(posedge clk)
    begin
        if (ctl.gcd_init)
        begin
            sn_reg <= sn_fix;
            sd_reg <= sd_fix;
            x_reg  <= rar_pkg::mag(sn_fix);
            y_reg  <= rar_pkg::mag(sd_fix);
            k_reg  <= '0;
        end
        else if (ctl.gcd_step)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            k_reg <= k_next;
        end

        if (ctl.div_load_num)
        begin
            g_reg   <= (x_reg | y_reg) << k_reg;
            quo_reg <= rar_pkg::mag(sn_reg);
            rem_reg <= '0;
            cnt_reg <= rar_pkg::CW'(W);
        end
        else if (ctl.div_load_den)
        begin
            qn_reg  <= quo_reg;
            quo_reg <= rar_pkg::mag(sd_reg);
            rem_reg <= '0;
            cnt_reg <= rar_pkg::CW'(W);
        end
        else if (ctl.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - rar_pkg::CW'(1);
        end
    end

    assign stat.is_reduce = (cmd_reg == rar_pkg::CMD_RED);
    assign stat.is_mul    = (cmd_reg == rar_pkg::CMD_MUL);
    assign stat.den_eq    = (ad_reg == bd_reg);
    assign stat.an_zero   = (an_reg == '0);
    assign stat.gcd_done  = (x_reg == '0) || (y_reg == '0);
    assign stat.div_last  = (cnt_reg == rar_pkg::CW'(1));

    assign res_num = rn_reg;
    assign res_den = rd_reg;

endmodule

@@ rtl/rar_ctrl.sv @@
// ----------------------------------------------------------------------------
// rar_ctrl: sequencer of the rational arithmetic unit
// One-hot state machine issuing datapath commands; owns the handshakes.
// ----------------------------------------------------------------------------
module rar_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  rar_pkg::dp_stat_t  stat,
    output rar_pkg::ctrl_cmd_t ctl
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_DECODE = 10'b00_0000_0010,
        S_MUL_P  = 10'b00_0000_0100,
        S_MUL_Q  = 10'b00_0000_1000,
        S_MUL_D  = 10'b00_0001_0000,
        S_GCD    = 10'b00_0010_0000,
        S_DIV_N  = 10'b00_0100_0000,
        S_SWAP   = 10'b00_1000_0000,
        S_DIV_D  = 10'b01_0000_0000,
        S_FINISH = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (stat.is_reduce)
                begin
                    if (stat.an_zero)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        ctl.gcd_init = 1'b1;
                        state_next   = S_GCD;
                    end
                end
                else if (stat.is_mul || !stat.den_eq)
                begin
                    state_next = S_MUL_P;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_MUL_P:
            begin
                ctl.mul_p  = 1'b1;
                state_next = stat.is_mul ? S_MUL_D : S_MUL_Q;
            end
            S_MUL_Q:
            begin
                ctl.mul_q  = 1'b1;
                state_next = S_MUL_D;
            end
            S_MUL_D:
            begin
                ctl.mul_d  = 1'b1;
                state_next = S_FINISH;
            end
            S_GCD:
            begin
                if (stat.gcd_done)
                begin
                    ctl.div_load_num = 1'b1;
                    state_next       = S_DIV_N;
                end
                else
                begin
                    ctl.gcd_step = 1'b1;
                end
            end
            S_DIV_N:
            begin
                ctl.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_SWAP;
                end
            end
            S_SWAP:
            begin
                ctl.div_load_den = 1'b1;
                state_next       = S_DIV_D;
            end
            S_DIV_D:
            begin
                ctl.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    ctl.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = ctl.res_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/rational_arith_reduce_core.sv @@
// ----------------------------------------------------------------------------
// rational_arith_reduce_core: rational number unit (add, sub, mul, reduce)
// Sequencer plus datapath; one request in flight, one-deep output register.
// ----------------------------------------------------------------------------
// Steps from accept to result valid: add/sub with equal denominators and
//   reduce of a zero numerator go from decode straight to finish; multiply
//   forms two products and add/sub otherwise three. Reduce runs the binary
//   gcd, then divides numerator and denominator on the restoring divider.
// Flow: one request at a time; the sequencer is back in idle, ready for the
//   next, once the result is in the output register, even while it waits.
// Reset (rst_n, async, active low) clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module rational_arith_reduce_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        command,
    input  logic signed [rar_pkg::WIDTH-1:0]  a_num,
    input  logic signed [rar_pkg::WIDTH-1:0]  a_den,
    input  logic signed [rar_pkg::WIDTH-1:0]  b_num,
    input  logic signed [rar_pkg::WIDTH-1:0]  b_den,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [rar_pkg::WIDTH-1:0]  res_num,
    output logic signed [rar_pkg::WIDTH-1:0]  res_den
);

    rar_pkg::ctrl_cmd_t ctl;
    rar_pkg::dp_stat_t  stat;

    // Sequencer: takes a request only when idle. Add/sub with unequal
    // denominators runs three products through the shared multiplier;
    // reduce runs the binary gcd, then divides numerator and denominator
    // magnitudes by g on one restoring divider, one bit per cycle.
    rar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Datapath: all sums and products wrap to WIDTH bits. The result
    // register only loads when the output slot is free, so a stalled
    // result holds.
    rar_dp u_dp (
        .clk     (clk),
        .ctl     (ctl),
        .stat    (stat),
        .command (command),
        .a_num   (a_num),
        .a_den   (a_den),
        .b_num   (b_num),
        .b_den   (b_den),
        .res_num (res_num),
        .res_den (res_den)
    );

endmodule
